>>> src/gcc_pkg.sv
// Shared constants and types of the clustering coefficient block.
`default_nettype none
package gcc_pkg;

    localparam int ID_W        = 6;
    localparam int NODES_REG_W = 7;
    localparam int EDGES_REG_W = 6;
    localparam int CFG_DATA_W  = 7;
    localparam int CNT_W       = 12;
    localparam int TOTAL_W     = 17;
    localparam int Q16_W       = 18;
    localparam int FRAC_W      = 16;
    localparam int QUO_W       = TOTAL_W + FRAC_W;
    localparam int DCNT_W      = $clog2(QUO_W + 1);

    localparam int MAX_NODES_DEF = 64;
    localparam int MAX_EDGES_DEF = 32;

    localparam logic [CNT_W-1:0]       COUNT_MAX   = 12'd4095;
    localparam logic [TOTAL_W-1:0]     TOTAL_MAX   = 17'h1FFFF;
    localparam logic [Q16_W-1:0]       Q16_MAX     = 18'h3FFFF;
    localparam logic [NODES_REG_W-1:0] NODES_RESET = 7'd64;
    localparam logic [EDGES_REG_W-1:0] EDGES_RESET = 6'd18;

    typedef enum logic {
        REG_NODES = 1'b0,
        REG_EDGES = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_LOAD,
        S_J_RD,
        S_J_WT,
        S_K_RD,
        S_K_WT,
        S_L_SCAN,
        S_MUL1,
        S_MUL2,
        S_DIV,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

>>> src/gcc_if.sv
// Channel interfaces of the clustering coefficient block: entries, results, configuration.
`default_nettype none
interface gcc_ent_if;
    import gcc_pkg::*;
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] neighbour_id;
    logic            last_entry;
    modport source (output valid, output neighbour_id, output last_entry, input ready);
    modport sink   (input valid, input neighbour_id, input last_entry, output ready);
endinterface

interface gcc_res_if;
    import gcc_pkg::*;
    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] total_links;
    logic [Q16_W-1:0]   cluster_q16;
    logic               bad_neighbour;
    logic               count_mismatch;
    modport source (output valid, output total_links, output cluster_q16,
                    output bad_neighbour, output count_mismatch, input ready);
    modport sink   (input valid, input total_links, input cluster_q16,
                    input bad_neighbour, input count_mismatch, output ready);
endinterface

interface gcc_cfg_if;
    import gcc_pkg::*;
    logic                  valid;
    logic                  ready;
    t_reg_idx              index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> src/graph_clustering_coefficient.sv
// Top level: adjacency store, evaluation sequencer and Q16 divider.
// The block takes a directed graph as a stream of neighbour ids, node after node, one entry
// request per cycle while loading. Entries go into a single adjacency memory with registered
// read data. The request flagged last_entry starts the evaluation, during which no entry is
// taken: for each node i and slot j the sequencer reads the first neighbour, for each slot k
// the second neighbour, then scans the first neighbour's row until it finds a match or reaches
// the row's end. All reads share the one memory read port. Evaluation is followed by the
// multiplication in S_MUL1 and S_MUL2 and a bit-serial division into QUO_W (33) quotient bits.
// The result request then waits in an output register until taken, after which loading resumes.
// Configuration writes are always taken and must only occur while the block is idle.
`default_nettype none
module graph_clustering_coefficient #(
    parameter int MAX_NODES = gcc_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = gcc_pkg::MAX_EDGES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gcc_cfg_if.sink   i_cfg,
    gcc_ent_if.sink   i_ent,
    gcc_res_if.source o_res
);
    import gcc_pkg::*;

    localparam int STORE_DEPTH = MAX_NODES * MAX_EDGES;
    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int NW  = $clog2(MAX_NODES + 1);
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int IW  = $clog2(MAX_NODES);
    localparam int SW  = $clog2(MAX_EDGES);
    localparam int XW  = ((AW > CNT_W) ? AW : CNT_W) + 1;
    localparam int NCW = (NW > NODES_REG_W) ? NW : NODES_REG_W;
    localparam int ECW = (EW > EDGES_REG_W) ? EW : EDGES_REG_W;
    localparam int NXW = (NW > ID_W) ? NW : ID_W;
    localparam int MXW = ((NW + EW) > CNT_W) ? (NW + EW) : CNT_W;
    localparam int DNW = 2 * EW + NW;

    // Adjacency memory
    logic [ID_W-1:0] r_adj_mem [STORE_DEPTH];
    logic [ID_W-1:0] r_rd_data;
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic            w_re;
    logic [AW-1:0]   w_raddr;

    // Control state
    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_load_count, n_load_count;
    logic                   r_bad, n_bad;
    logic [NODES_REG_W-1:0] r_nodes, n_nodes;
    logic [EDGES_REG_W-1:0] r_edges, n_edges;
    logic                   r_pend, n_pend;

    // Datapath
    logic [IW-1:0]      r_i, n_i;
    logic [SW-1:0]      r_j, n_j;
    logic [SW-1:0]      r_k, n_k;
    logic [SW-1:0]      r_l, n_l;
    logic               r_l_end, n_l_end;
    logic               r_pend_ok, n_pend_ok;
    logic               r_pend_last, n_pend_last;
    logic [AW-1:0]      r_base_i, n_base_i;
    logic [AW-1:0]      r_base1, n_base1;
    logic [ID_W-1:0]    r_n2, n_n2;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [DNW-1:0]     r_den, n_den;
    logic [DNW:0]       r_rem, n_rem;
    logic [QUO_W-1:0]   r_quo, n_quo;
    logic [DCNT_W-1:0]  r_dcnt, n_dcnt;
    logic               r_mis, n_mis;

    logic [NW-1:0] w_n;
    logic [EW-1:0] w_e;
    logic [AW-1:0] w_pos;
    logic          w_pos_ok;
    logic          w_rd_in_range;
    logic          w_adv_k;
    logic          w_adv_j;
    logic [DNW:0]  w_rem_sh;
    logic          w_qbit;

    // Effective node and slot counts, clamped to the supported range.
    always_comb begin
        if (NCW'(r_nodes) < NCW'(2)) begin
            w_n = NW'(2);
        end else if (NCW'(r_nodes) > NCW'(MAX_NODES)) begin
            w_n = NW'(MAX_NODES);
        end else begin
            w_n = NW'(r_nodes);
        end
        if (ECW'(r_edges) < ECW'(2)) begin
            w_e = EW'(2);
        end else if (ECW'(r_edges) > ECW'(MAX_EDGES)) begin
            w_e = EW'(MAX_EDGES);
        end else begin
            w_e = EW'(r_edges);
        end
    end

    assign w_rd_in_range = NXW'(r_rd_data) < NXW'(w_n);
    assign w_rem_sh      = {r_rem[DNW-1:0], r_quo[QUO_W-1]};
    assign w_qbit        = w_rem_sh >= {1'b0, r_den};

    assign i_cfg.ready = 1'b1;
    assign i_ent.ready = (r_state == S_LOAD);

    assign o_res.valid          = (r_state == S_OUT);
    assign o_res.total_links    = r_total;
    assign o_res.cluster_q16    = (|r_quo[QUO_W-1:Q16_W]) ? Q16_MAX : r_quo[Q16_W-1:0];
    assign o_res.bad_neighbour  = r_bad;
    assign o_res.count_mismatch = r_mis;

    always_comb begin
        n_state      = r_state;
        n_load_count = r_load_count;
        n_bad        = r_bad;
        n_nodes      = r_nodes;
        n_edges      = r_edges;
        n_pend       = 1'b0;
        n_i          = r_i;
        n_j          = r_j;
        n_k          = r_k;
        n_l          = r_l;
        n_l_end      = r_l_end;
        n_pend_ok    = r_pend_ok;
        n_pend_last  = r_pend_last;
        n_base_i     = r_base_i;
        n_base1      = r_base1;
        n_n2         = r_n2;
        n_total      = r_total;
        n_den        = r_den;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_dcnt       = r_dcnt;
        n_mis        = r_mis;
        w_we         = 1'b0;
        w_waddr      = AW'(r_load_count);
        w_re         = 1'b0;
        w_raddr      = '0;
        w_pos        = '0;
        w_pos_ok     = 1'b0;
        w_adv_k      = 1'b0;
        w_adv_j      = 1'b0;

        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_NODES: n_nodes = i_cfg.data[NODES_REG_W-1:0];
                REG_EDGES: n_edges = i_cfg.data[EDGES_REG_W-1:0];
                default:   n_nodes = r_nodes;
            endcase
        end

        unique case (r_state)
            S_LOAD: begin
                if (i_ent.valid) begin
                    w_we = XW'(r_load_count) < XW'(STORE_DEPTH);
                    if (r_load_count != COUNT_MAX) begin
                        n_load_count = r_load_count + CNT_W'(1);
                    end
                    if (NXW'(i_ent.neighbour_id) >= NXW'(w_n)) begin
                        n_bad = 1'b1;
                    end
                    if (i_ent.last_entry) begin
                        n_i      = '0;
                        n_j      = '0;
                        n_base_i = '0;
                        n_total  = '0;
                        n_state  = S_J_RD;
                    end
                end
            end
            S_J_RD: begin
                w_pos    = r_base_i + AW'(r_j);
                w_pos_ok = XW'(w_pos) < XW'(r_load_count);
                w_re     = w_pos_ok;
                w_raddr  = w_pos;
                if (w_pos_ok) begin
                    n_state = S_J_WT;
                end else begin
                    w_adv_j = 1'b1;
                end
            end
            S_J_WT: begin
                if (w_rd_in_range) begin
                    n_base1 = AW'(AW'(r_rd_data) * AW'(w_e));
                    n_k     = '0;
                    n_state = S_K_RD;
                end else begin
                    w_adv_j = 1'b1;
                end
            end
            S_K_RD: begin
                w_pos    = r_base_i + AW'(r_k);
                w_pos_ok = XW'(w_pos) < XW'(r_load_count);
                w_re     = w_pos_ok;
                w_raddr  = w_pos;
                if (w_pos_ok) begin
                    n_state = S_K_WT;
                end else begin
                    w_adv_k = 1'b1;
                end
            end
            S_K_WT: begin
                if (w_rd_in_range) begin
                    n_n2    = r_rd_data;
                    n_l     = '0;
                    n_l_end = 1'b0;
                    n_pend  = 1'b0;
                    n_state = S_L_SCAN;
                end else begin
                    w_adv_k = 1'b1;
                end
            end
            S_L_SCAN: begin
                // Reads of the first neighbour's row are issued back to back; each one is compared in the
                // cycle after it is issued, and a hit abandons the read still in flight.
                if (!r_l_end) begin
                    w_pos       = r_base1 + AW'(r_l);
                    w_re        = 1'b1;
                    w_raddr     = w_pos;
                    n_pend      = 1'b1;
                    n_pend_ok   = XW'(w_pos) < XW'(r_load_count);
                    n_pend_last = (EW'(r_l) + EW'(1)) == w_e;
                    if ((EW'(r_l) + EW'(1)) == w_e) begin
                        n_l_end = 1'b1;
                    end else begin
                        n_l = r_l + SW'(1);
                    end
                end
                if (r_pend && r_pend_ok && w_rd_in_range && (r_rd_data == r_n2)) begin
                    if (r_total != TOTAL_MAX) begin
                        n_total = r_total + TOTAL_W'(1);
                    end
                    w_adv_k = 1'b1;
                end else if (r_pend && r_pend_last) begin
                    w_adv_k = 1'b1;
                end
            end
            S_MUL1: begin
                n_den   = DNW'(w_e) * DNW'(w_e - EW'(1));
                n_mis   = MXW'(r_load_count) != (MXW'(w_n) * MXW'(w_e));
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_den   = r_den * DNW'(w_n);
                n_rem   = '0;
                n_quo   = {r_total, {FRAC_W{1'b0}}};
                n_dcnt  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem  = w_qbit ? (w_rem_sh - {1'b0, r_den}) : w_rem_sh;
                n_quo  = {r_quo[QUO_W-2:0], w_qbit};
                n_dcnt = r_dcnt + DCNT_W'(1);
                if (r_dcnt == DCNT_W'(QUO_W - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (o_res.ready) begin
                    n_load_count = '0;
                    n_bad        = 1'b0;
                    n_state      = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase

        if (w_adv_k) begin
            if ((EW'(r_k) + EW'(1)) == w_e) begin
                w_adv_j = 1'b1;
            end else begin
                n_k     = r_k + SW'(1);
                n_state = S_K_RD;
            end
        end
        if (w_adv_j) begin
            if ((EW'(r_j) + EW'(1)) == w_e) begin
                if ((NW'(r_i) + NW'(1)) == w_n) begin
                    n_state = S_MUL1;
                end else begin
                    n_i      = r_i + IW'(1);
                    n_base_i = r_base_i + AW'(w_e);
                    n_j      = '0;
                    n_state  = S_J_RD;
                end
            end else begin
                n_j     = r_j + SW'(1);
                n_state = S_J_RD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_adj_mem[w_waddr] <= i_ent.neighbour_id;
        end
        if (w_re) begin
            r_rd_data <= r_adj_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_load_count <= '0;
            r_bad        <= 1'b0;
            r_nodes      <= NODES_RESET;
            r_edges      <= EDGES_RESET;
            r_pend       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_load_count <= n_load_count;
            r_bad        <= n_bad;
            r_nodes      <= n_nodes;
            r_edges      <= n_edges;
            r_pend       <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i         <= n_i;
        r_j         <= n_j;
        r_k         <= n_k;
        r_l         <= n_l;
        r_l_end     <= n_l_end;
        r_pend_ok   <= n_pend_ok;
        r_pend_last <= n_pend_last;
        r_base_i    <= n_base_i;
        r_base1     <= n_base1;
        r_n2        <= n_n2;
        r_total     <= n_total;
        r_den       <= n_den;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_dcnt      <= n_dcnt;
        r_mis       <= n_mis;
    end

endmodule
`default_nettype wire
